>>> hw/rtl/whp_pkg.sv
// Shared types, codes and constants of the WAV header parser.
package whp_pkg;

  localparam int unsigned DIV_W      = 32;
  localparam int unsigned DIVISOR_W  = 16;
  localparam int unsigned FRAME_W    = 30;

  localparam logic [15:0] MAX_SKIPPED_RESET = 16'd1000;
  localparam logic [31:0] TAG_RIFF          = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE          = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT           = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA          = 32'h6174_6164;
  localparam logic [31:0] FMT_BODY_LEN      = 32'd16;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_FORMAT  = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [2:0] ERR_NOT_WAVE     = 3'd0;
  localparam logic [2:0] ERR_FMT_MISSING  = 3'd1;
  localparam logic [2:0] ERR_UNSUPPORTED  = 3'd2;
  localparam logic [2:0] ERR_DATA_MISSING = 3'd3;
  localparam logic [2:0] ERR_TOO_LARGE    = 3'd4;

  localparam logic [1:0] SKIND_UNSIGNED = 2'd0;
  localparam logic [1:0] SKIND_SIGNED   = 2'd1;
  localparam logic [1:0] SKIND_FLOAT    = 2'd2;

  typedef enum logic [3:0] {
    PH_RIFF         = 4'd0,
    PH_RIFF_LEN     = 4'd1,
    PH_WAVE         = 4'd2,
    PH_FMT_TAG      = 4'd3,
    PH_FMT_SKIPLEN  = 4'd4,
    PH_FMT_SKIP     = 4'd5,
    PH_FMT_LEN      = 4'd6,
    PH_FMT_BODY     = 4'd7,
    PH_FMT_EXTRA    = 4'd8,
    PH_DATA_TAG     = 4'd9,
    PH_DATA_SKIPLEN = 4'd10,
    PH_DATA_SKIP    = 4'd11,
    PH_DATA_LEN     = 4'd12,
    PH_PAYLOAD      = 4'd13,
    PH_WAIT         = 4'd14,
    PH_DIVIDE       = 4'd15
  } phase_t;

  typedef enum logic [1:0] {
    OSEL_PAYLOAD = 2'd0,
    OSEL_FORMAT  = 2'd1,
    OSEL_ERROR   = 2'd2
  } osel_t;

  typedef struct packed {
    logic       shift_tag;
    logic       idx_inc;
    logic       idx_clr;
    logic       chunk_load;
    logic       skip_load_tag;
    logic       skip_load_extra;
    logic       skip_dec;
    logic       skip_cnt_inc;
    logic       fmt_clear;
    logic       body_write;
    logic       data_load;
    logic       data_dec;
    logic       div_start;
    logic       restart;
    logic       out_load;
    osel_t      out_sel;
    logic [2:0] out_code;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic idx_is3;
    logic idx_is15;
    logic tag_riff;
    logic tag_wave;
    logic tag_fmt;
    logic tag_data;
    logic tag_zero;
    logic tag_lt16;
    logic skip_over;
    logic skip_is1;
    logic fmt_ok;
    logic extra_zero;
    logic data_is1;
    logic div_busy;
    logic quot_zero;
    logic chunk_big;
  } sts_t;

endpackage

>>> hw/rtl/whp_divider.sv
// Restoring divider, one quotient bit per cycle, for the frame count.
module whp_divider
  import whp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 busy,
  output logic [DIV_W-1:0]     quotient
);

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0]     quo_r;
  logic [DIVISOR_W-1:0] rem_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;

  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W+1:0] diff;
  logic                 ge;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};
  assign ge      = !diff[DIVISOR_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

>>> hw/rtl/whp_datapath.sv
// Datapath of the WAV header parser: fields, counters, divider and result register.
module whp_datapath
  import whp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_file_byte,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic [1:0]         out_result_kind,
  output logic [7:0]         out_payload_byte,
  output logic [1:0]         out_channels,
  output logic [31:0]        out_sample_rate,
  output logic [5:0]         out_sample_bits,
  output logic [1:0]         out_sample_kind,
  output logic [FRAME_W-1:0] out_frame_count,
  output logic [2:0]         out_error_code,
  output logic               out_last
);

  logic [15:0]        max_skipped_r;
  logic [15:0]        skipped_r;
  logic [3:0]         idx_r;
  logic [31:0]        tag_r;
  logic [31:0]        chunk_r;
  logic [31:0]        skip_r;
  logic [15:0]        fmt_tag_r;
  logic [15:0]        ch_r;
  logic [31:0]        rate_r;
  logic [15:0]        align_r;
  logic [15:0]        bits_r;
  logic [FRAME_W-1:0] data_r;

  logic [1:0]         kind_r;
  logic [7:0]         payload_r;
  logic [1:0]         channels_r;
  logic [31:0]        srate_r;
  logic [5:0]         sbits_r;
  logic [1:0]         skind_r;
  logic [FRAME_W-1:0] frames_r;
  logic [2:0]         code_r;
  logic               last_r;

  logic [31:0]        tag_nxt;
  logic [15:0]        bits_full;
  logic [15:0]        align_want;
  logic               bits_good;
  logic               ch_good;
  logic [1:0]         skind;
  logic               div_busy;
  logic [DIV_W-1:0]   quotient;

  assign tag_nxt   = {in_file_byte, tag_r[31:8]};
  assign bits_full = {in_file_byte, bits_r[7:0]};
  assign bits_good = (bits_full == 16'd8) || (bits_full == 16'd16) ||
                     (bits_full == 16'd24) || (bits_full == 16'd32);
  assign ch_good   = (ch_r == 16'd1) || (ch_r == 16'd2);
  assign align_want = (ch_r == 16'd2) ? {12'd0, bits_full[5:3], 1'b0}
                                      : {13'd0, bits_full[5:3]};

  always_comb begin
    if (bits_r == 16'd8) begin
      skind = SKIND_UNSIGNED;
    end else if (bits_r == 16'd32) begin
      skind = SKIND_FLOAT;
    end else begin
      skind = SKIND_SIGNED;
    end
  end

  whp_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (tag_nxt),
    .divisor  (align_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_comb begin
    sts.idx_is3    = (idx_r == 4'd3);
    sts.idx_is15   = (idx_r == 4'd15);
    sts.tag_riff   = (tag_nxt == TAG_RIFF);
    sts.tag_wave   = (tag_nxt == TAG_WAVE);
    sts.tag_fmt    = (tag_nxt == TAG_FMT);
    sts.tag_data   = (tag_nxt == TAG_DATA);
    sts.tag_zero   = (tag_nxt == 32'd0);
    sts.tag_lt16   = (tag_nxt < FMT_BODY_LEN);
    sts.skip_over  = (({1'b0, skipped_r} + 17'd1) > {1'b0, max_skipped_r});
    sts.skip_is1   = (skip_r == 32'd1);
    sts.fmt_ok     = (fmt_tag_r == 16'd1) && ch_good && bits_good &&
                     (align_r == align_want);
    sts.extra_zero = (chunk_r == FMT_BODY_LEN);
    sts.data_is1   = (data_r == FRAME_W'(1));
    sts.div_busy   = div_busy;
    sts.quot_zero  = (quotient == '0) || (align_r == 16'd0);
    sts.chunk_big  = (chunk_r[31:FRAME_W] != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_skipped_r <= MAX_SKIPPED_RESET;
    end else if (cfg_wr_en) begin
      max_skipped_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      skipped_r <= '0;
    end else begin
      if (cmd.restart || cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 4'd1;
      end
      if (cmd.restart) begin
        skipped_r <= '0;
      end else if (cmd.skip_cnt_inc) begin
        skipped_r <= skipped_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_tag) begin
      tag_r <= tag_nxt;
    end
    if (cmd.chunk_load) begin
      chunk_r <= tag_nxt;
    end
    if (cmd.skip_load_tag) begin
      skip_r <= tag_nxt;
    end else if (cmd.skip_load_extra) begin
      skip_r <= chunk_r - FMT_BODY_LEN;
    end else if (cmd.skip_dec) begin
      skip_r <= skip_r - 32'd1;
    end
    if (cmd.data_load) begin
      data_r <= chunk_r[FRAME_W-1:0];
    end else if (cmd.data_dec) begin
      data_r <= data_r - FRAME_W'(1);
    end
    if (cmd.fmt_clear) begin
      fmt_tag_r <= '0;
      ch_r      <= '0;
      rate_r    <= '0;
      align_r   <= '0;
      bits_r    <= '0;
    end else if (cmd.body_write) begin
      case (idx_r)
        4'd0:    fmt_tag_r[7:0]   <= in_file_byte;
        4'd1:    fmt_tag_r[15:8]  <= in_file_byte;
        4'd2:    ch_r[7:0]        <= in_file_byte;
        4'd3:    ch_r[15:8]       <= in_file_byte;
        4'd4:    rate_r[7:0]      <= in_file_byte;
        4'd5:    rate_r[15:8]     <= in_file_byte;
        4'd6:    rate_r[23:16]    <= in_file_byte;
        4'd7:    rate_r[31:24]    <= in_file_byte;
        4'd12:   align_r[7:0]     <= in_file_byte;
        4'd13:   align_r[15:8]    <= in_file_byte;
        4'd14:   bits_r[7:0]      <= in_file_byte;
        4'd15:   bits_r[15:8]     <= in_file_byte;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind_r     <= KIND_ERROR;
      payload_r  <= '0;
      channels_r <= '0;
      srate_r    <= '0;
      sbits_r    <= '0;
      skind_r    <= '0;
      frames_r   <= '0;
      code_r     <= '0;
      last_r     <= cmd.out_last;
      case (cmd.out_sel)
        OSEL_PAYLOAD: begin
          kind_r    <= KIND_PAYLOAD;
          payload_r <= in_file_byte;
        end
        OSEL_FORMAT: begin
          kind_r     <= KIND_FORMAT;
          channels_r <= ch_r[1:0];
          srate_r    <= rate_r;
          sbits_r    <= bits_r[5:0];
          skind_r    <= skind;
          frames_r   <= quotient[FRAME_W-1:0];
        end
        default: begin
          kind_r <= KIND_ERROR;
          code_r <= cmd.out_code;
        end
      endcase
    end
  end

  assign out_result_kind  = kind_r;
  assign out_payload_byte = payload_r;
  assign out_channels     = channels_r;
  assign out_sample_rate  = srate_r;
  assign out_sample_bits  = sbits_r;
  assign out_sample_kind  = skind_r;
  assign out_frame_count  = frames_r;
  assign out_error_code   = code_r;
  assign out_last         = last_r;

endmodule

>>> hw/rtl/whp_ctrl.sv
// Parse controller of the WAV header parser: phase machine and result sequencing.
module whp_ctrl
  import whp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_end_of_file,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  phase_t     phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       pend_r, pend_nxt;
  logic [2:0] pend_code_r, pend_code_nxt;
  logic       eof_hold_r, eof_hold_nxt;

  phase_t     ph_step;
  logic       step_err;
  logic [2:0] step_code;
  logic       step_pay;
  logic       eof_err;
  logic [2:0] eof_code;
  logic       out_free;
  logic       accept;
  logic       div_fire;
  logic       div_err;
  logic [2:0] div_code;
  logic       restart;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((phase_r != PH_DIVIDE) && !pend_r && out_free);
  assign accept   = in_valid && !in_stall;
  assign div_fire = (phase_r == PH_DIVIDE) && !sts.div_busy && out_free && !pend_r;
  assign div_err  = sts.quot_zero || sts.chunk_big;
  assign div_code = sts.quot_zero ? ERR_DATA_MISSING : ERR_TOO_LARGE;
  assign restart  = (accept && in_end_of_file && (ph_step != PH_DIVIDE)) ||
                    (div_fire && eof_hold_r);
  assign out_valid = out_valid_r;

  always_comb begin
    ph_step   = phase_r;
    step_err  = 1'b0;
    step_code = ERR_NOT_WAVE;
    step_pay  = 1'b0;
    unique case (phase_r) inside
      PH_RIFF: begin
        if (sts.idx_is3) begin
          if (sts.tag_riff) ph_step = PH_RIFF_LEN;
          else step_err = 1'b1;
        end
      end
      PH_RIFF_LEN: begin
        if (sts.idx_is3) ph_step = PH_WAVE;
      end
      PH_WAVE: begin
        if (sts.idx_is3) begin
          if (sts.tag_wave) ph_step = PH_FMT_TAG;
          else step_err = 1'b1;
        end
      end
      PH_FMT_TAG: begin
        if (sts.idx_is3) begin
          if (sts.tag_fmt) begin
            ph_step = PH_FMT_LEN;
          end else if (sts.skip_over) begin
            step_err  = 1'b1;
            step_code = ERR_FMT_MISSING;
          end else begin
            ph_step = PH_FMT_SKIPLEN;
          end
        end
      end
      PH_DATA_TAG: begin
        if (sts.idx_is3) begin
          if (sts.tag_data) begin
            ph_step = PH_DATA_LEN;
          end else if (sts.skip_over) begin
            step_err  = 1'b1;
            step_code = ERR_DATA_MISSING;
          end else begin
            ph_step = PH_DATA_SKIPLEN;
          end
        end
      end
      PH_FMT_SKIPLEN: begin
        if (sts.idx_is3) ph_step = sts.tag_zero ? PH_FMT_TAG : PH_FMT_SKIP;
      end
      PH_DATA_SKIPLEN: begin
        if (sts.idx_is3) ph_step = sts.tag_zero ? PH_DATA_TAG : PH_DATA_SKIP;
      end
      PH_FMT_LEN: begin
        if (sts.idx_is3) begin
          if (sts.tag_lt16) begin
            step_err  = 1'b1;
            step_code = ERR_FMT_MISSING;
          end else begin
            ph_step = PH_FMT_BODY;
          end
        end
      end
      PH_DATA_LEN: begin
        if (sts.idx_is3) ph_step = PH_DIVIDE;
      end
      PH_FMT_SKIP: begin
        if (sts.skip_is1) ph_step = PH_FMT_TAG;
      end
      PH_DATA_SKIP, PH_FMT_EXTRA: begin
        if (sts.skip_is1) ph_step = PH_DATA_TAG;
      end
      PH_FMT_BODY: begin
        if (sts.idx_is15) begin
          if (!sts.fmt_ok) begin
            step_err  = 1'b1;
            step_code = ERR_UNSUPPORTED;
          end else begin
            ph_step = sts.extra_zero ? PH_DATA_TAG : PH_FMT_EXTRA;
          end
        end
      end
      PH_PAYLOAD: begin
        step_pay = 1'b1;
        if (sts.data_is1) ph_step = PH_WAIT;
      end
      PH_WAIT, PH_DIVIDE: ;
      default: ;
    endcase
    if (step_err) ph_step = PH_WAIT;
  end

  always_comb begin
    eof_err = accept && in_end_of_file && !step_err &&
              (ph_step != PH_WAIT) && (ph_step != PH_DIVIDE);
    unique case (ph_step) inside
      PH_RIFF, PH_RIFF_LEN, PH_WAVE: eof_code = ERR_NOT_WAVE;
      PH_FMT_TAG, PH_FMT_SKIPLEN, PH_FMT_SKIP, PH_FMT_LEN, PH_FMT_BODY,
      PH_FMT_EXTRA: eof_code = ERR_FMT_MISSING;
      default: eof_code = ERR_DATA_MISSING;
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    pend_nxt      = pend_r;
    pend_code_nxt = pend_code_r;
    eof_hold_nxt  = eof_hold_r;
    if (accept) begin
      phase_nxt = restart ? PH_RIFF : ph_step;
      if (ph_step == PH_DIVIDE) eof_hold_nxt = in_end_of_file;
      if (eof_err && step_pay) begin
        pend_nxt      = 1'b1;
        pend_code_nxt = eof_code;
      end
    end else if (div_fire) begin
      phase_nxt = eof_hold_r ? PH_RIFF : (div_err ? PH_WAIT : PH_PAYLOAD);
      if (!div_err && eof_hold_r) begin
        pend_nxt      = 1'b1;
        pend_code_nxt = ERR_DATA_MISSING;
      end
    end else if (pend_r && out_free) begin
      pend_nxt = 1'b0;
    end
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_comb begin
    cmd          = '0;
    cmd.out_sel  = OSEL_ERROR;
    cmd.out_code = ERR_NOT_WAVE;
    cmd.restart  = restart;
    if (accept) begin
      unique case (phase_r) inside
        PH_RIFF, PH_RIFF_LEN, PH_WAVE, PH_FMT_TAG, PH_DATA_TAG, PH_FMT_SKIPLEN,
        PH_DATA_SKIPLEN, PH_FMT_LEN, PH_DATA_LEN: begin
          cmd.shift_tag = 1'b1;
          cmd.idx_inc   = 1'b1;
          if (sts.idx_is3) begin
            cmd.idx_clr    = 1'b1;
            cmd.chunk_load = 1'b1;
            if (phase_r == PH_FMT_TAG) cmd.skip_cnt_inc = !sts.tag_fmt && !sts.skip_over;
            if (phase_r == PH_DATA_TAG) cmd.skip_cnt_inc = !sts.tag_data && !sts.skip_over;
            if (phase_r == PH_FMT_SKIPLEN || phase_r == PH_DATA_SKIPLEN) begin
              cmd.skip_load_tag = 1'b1;
            end
            if (phase_r == PH_FMT_LEN) cmd.fmt_clear = !sts.tag_lt16;
            if (phase_r == PH_DATA_LEN) cmd.div_start = 1'b1;
          end
        end
        PH_FMT_SKIP, PH_DATA_SKIP, PH_FMT_EXTRA: cmd.skip_dec = 1'b1;
        PH_FMT_BODY: begin
          cmd.body_write = 1'b1;
          cmd.idx_inc    = 1'b1;
          if (sts.idx_is15) begin
            cmd.idx_clr         = 1'b1;
            cmd.skip_load_extra = sts.fmt_ok;
          end
        end
        PH_PAYLOAD: cmd.data_dec = 1'b1;
        default: ;
      endcase
    end
    if (pend_r && out_free) begin
      cmd.out_load = 1'b1;
      cmd.out_sel  = OSEL_ERROR;
      cmd.out_code = pend_code_r;
      cmd.out_last = 1'b1;
    end else if (accept && (step_err || step_pay || eof_err)) begin
      cmd.out_load = 1'b1;
      if (step_err) begin
        cmd.out_code = step_code;
        cmd.out_last = 1'b1;
      end else if (step_pay) begin
        cmd.out_sel  = OSEL_PAYLOAD;
        cmd.out_last = sts.data_is1;
      end else begin
        cmd.out_code = eof_code;
        cmd.out_last = 1'b1;
      end
    end else if (div_fire) begin
      cmd.out_load = 1'b1;
      if (div_err) begin
        cmd.out_code = div_code;
        cmd.out_last = 1'b1;
      end else begin
        cmd.out_sel   = OSEL_FORMAT;
        cmd.data_load = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_RIFF;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      pend_code_r <= ERR_NOT_WAVE;
      eof_hold_r  <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      pend_code_r <= pend_code_nxt;
      eof_hold_r  <= eof_hold_nxt;
    end
  end

endmodule

>>> hw/rtl/wav_header_parser.sv
// Top level of the WAV header parser: controller and datapath.
// A result for an accepted byte shows in the output register in the following cycle.
// Bytes are taken at one per cycle while the output drains, except during the divide
// or while an error is pending. The data length field starts the divide; the format
// beat follows it. An end-of-file error behind a payload or format beat trails it.
// Synchronous active-low reset restarts parsing and sets max_skipped_chunks to 1000.
module wav_header_parser
  import whp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_file_byte,
  input  logic               in_end_of_file,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_result_kind,
  output logic [7:0]         out_payload_byte,
  output logic [1:0]         out_channels,
  output logic [31:0]        out_sample_rate,
  output logic [5:0]         out_sample_bits,
  output logic [1:0]         out_sample_kind,
  output logic [FRAME_W-1:0] out_frame_count,
  output logic [2:0]         out_error_code,
  output logic               out_last,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  whp_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_end_of_file (in_end_of_file),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sts            (sts),
    .cmd            (cmd)
  );

  whp_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_file_byte     (in_file_byte),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .cmd              (cmd),
    .sts              (sts),
    .out_result_kind  (out_result_kind),
    .out_payload_byte (out_payload_byte),
    .out_channels     (out_channels),
    .out_sample_rate  (out_sample_rate),
    .out_sample_bits  (out_sample_bits),
    .out_sample_kind  (out_sample_kind),
    .out_frame_count  (out_frame_count),
    .out_error_code   (out_error_code),
    .out_last         (out_last)
  );

endmodule

>>> hw/rtl/whp_checker.sv
// Port-level assertions for the WAV header parser and their bind.
module whp_checker
  import whp_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_result_kind,
  input logic [7:0]         out_payload_byte,
  input logic [1:0]         out_channels,
  input logic [FRAME_W-1:0] out_frame_count,
  input logic [2:0]         out_error_code,
  input logic               out_last
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind) &&
    $stable(out_payload_byte) && $stable(out_error_code) && $stable(out_last))
    else $error("Stalled result beat changed or vanished.");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_ERROR) |-> out_last &&
    (out_error_code <= ERR_TOO_LARGE))
    else $error("Error beat without last or with a bad code.");

  a_format_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_FORMAT) |->
    ((out_channels == 2'd1) || (out_channels == 2'd2)) &&
    (out_frame_count != '0) && !out_last)
    else $error("Format beat with bad channels, zero frames or last set.");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_kind == KIND_PAYLOAD) ||
    (out_result_kind == KIND_FORMAT) || (out_result_kind == KIND_ERROR))
    else $error("Result beat with an unknown kind.");

endmodule

bind wav_header_parser whp_checker u_whp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_kind  (out_result_kind),
  .out_payload_byte (out_payload_byte),
  .out_channels     (out_channels),
  .out_frame_count  (out_frame_count),
  .out_error_code   (out_error_code),
  .out_last         (out_last)
);
